// ----- sv/tfq_pkg.sv -----
// ============================================================================
// tfq_pkg
// Shared types and constants of the three-level feedback queue scheduler.
// ============================================================================
package tfq_pkg;

   localparam int ID_W          = 6;
   localparam int ID_SPACE      = 64;
   localparam int CNT_W         = 7;
   localparam int USED_W        = 9;
   localparam int CHG_W         = 8;
   localparam int SLICE_W       = 8;
   localparam int PERIOD_W      = 10;
   localparam int LVL_W         = 2;
   localparam int NUM_LEVELS    = 3;
   localparam int DEF_MAX_TASKS = 64;

   localparam logic [USED_W-1:0]   USED_MAX      = '1;
   localparam logic [SLICE_W-1:0]  SLICE_RESET   = SLICE_W'(8);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(20);

   // Register indexes of the configuration port.
   localparam logic REG_TIME_SLICE   = 1'b0;
   localparam logic REG_BOOST_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_KILL = 2'd1,
      OP_SET  = 2'd2,
      OP_PICK = 2'd3
   } op_type;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_UNKNOWN = 2'd2;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [ID_W-1:0]  task_id;
      logic [CHG_W-1:0] charge;
      logic             active_flag;
      logic             spawn_room;
   } req_item_type;

   typedef struct packed {
      logic             picked_valid;
      logic [ID_W-1:0]  picked_id;
      logic [LVL_W-1:0] picked_level;
      logic [CNT_W-1:0] task_total;
      status_type       status;
   } rsp_item_type;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      op_type           op;
      logic [ID_W-1:0]  id;
      logic [CHG_W-1:0] charge;
      logic             act;
      logic             room;
   } cmd_type;

   typedef struct packed {
      logic [SLICE_W-1:0]  time_slice;
      logic [PERIOD_W-1:0] boost_period;
   } cfg_type;

endpackage

// ----- sv/tfq_front.sv -----
// ============================================================================
// tfq_front
// Accepts command beats, classifies them and holds them in a two-entry queue
// for the scheduling engine.
// ============================================================================
module tfq_front
   import tfq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         q_valid,
   output cmd_type      q_cmd,
   input  logic         q_take
);

   cmd_type    q_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   // Classify the incoming beat into a command.
   always_comb begin
      cmd_in.op     = op_type'(req_item.opcode);
      cmd_in.id     = req_item.task_id;
      cmd_in.charge = req_item.charge;
      cmd_in.act    = req_item.active_flag;
      cmd_in.room   = req_item.spawn_room;
   end

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop     = q_take && q_valid;
   assign q_cmd   = q_ff[rd_ptr_ff];

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- sv/tfq_back.sv -----
// ============================================================================
// tfq_back
// Scheduling engine: keeps the three linked task queues and carries out add,
// kill, set-active and the multi-pass pick, one queue element at a time.
// ============================================================================
module tfq_back
   import tfq_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS
)
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  cmd_type      q_cmd,
   output logic         q_take,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int CAP = (MAX_TASKS < ID_SPACE) ? MAX_TASKS : ID_SPACE;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EXEC = 6'b000010,
      S_INIT = 6'b000100,
      S_RD   = 6'b001000,
      S_EX   = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   typedef enum logic [9:0] {
      PH_PURGE0 = 10'b0000000001,
      PH_PURGE1 = 10'b0000000010,
      PH_PURGE2 = 10'b0000000100,
      PH_BOOST1 = 10'b0000001000,
      PH_BOOST2 = 10'b0000010000,
      PH_DEM1   = 10'b0000100000,
      PH_DEM0   = 10'b0001000000,
      PH_ROT0   = 10'b0010000000,
      PH_ROT1   = 10'b0100000000,
      PH_ROT2   = 10'b1000000000
   } phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in, phase_nxt;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [ID_W-1:0]     cur_ff, cur_in;
   logic [ID_W-1:0]     head_ff [NUM_LEVELS];
   logic [ID_W-1:0]     head_in [NUM_LEVELS];
   logic [ID_W-1:0]     tail_ff [NUM_LEVELS];
   logic [ID_W-1:0]     tail_in [NUM_LEVELS];
   logic [CNT_W-1:0]    count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]    count_in [NUM_LEVELS];
   logic [ID_SPACE-1:0] present_ff, present_in;
   logic [ID_SPACE-1:0] alive_ff, alive_in;
   logic [ID_SPACE-1:0] active_ff, active_in;
   logic [PERIOD_W-1:0] pick_cnt_ff, pick_cnt_in;
   rsp_item_type        res_ff, res_in;

   // Per-task memories with registered reads.
   logic [ID_W-1:0]   link_mem [ID_SPACE];
   logic [USED_W-1:0] used_mem [ID_SPACE];
   logic [CHG_W-1:0]  chg_mem  [ID_SPACE];
   logic [ID_W-1:0]   link_rd;
   logic [USED_W-1:0] used_rd;
   logic [CHG_W-1:0]  chg_rd;
   logic [ID_W-1:0]   rd_addr;
   logic              lw_en, uw_en, cw_en;
   logic [ID_W-1:0]   lw_addr, lw_data, uw_addr, cw_addr;
   logic [USED_W-1:0] uw_data;
   logic [CHG_W-1:0]  cw_data;

   logic [LVL_W-1:0]  src_lv, dst_lv;
   logic              pop_en, push_en;
   logic [LVL_W-1:0]  push_lv;
   logic [ID_W-1:0]   push_id;
   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  n_dec;
   logic              pass_end;
   logic [USED_W:0]   used_sum;

   assign total    = count_ff[0] + count_ff[1] + count_ff[2];
   assign rd_addr  = head_ff[src_lv];
   assign used_sum = {1'b0, used_rd} + {2'b00, chg_rd};
   assign n_dec    = n_ff - CNT_W'(1);

   // Source and destination level of each pass, and the pass that follows.
   always_comb begin
      src_lv    = 2'd0;
      dst_lv    = 2'd0;
      phase_nxt = PH_PURGE0;
      unique case (phase_ff)
         PH_PURGE0: begin src_lv = 2'd0; dst_lv = 2'd0; phase_nxt = PH_PURGE1; end
         PH_PURGE1: begin src_lv = 2'd1; dst_lv = 2'd1; phase_nxt = PH_PURGE2; end
         PH_PURGE2: begin src_lv = 2'd2; dst_lv = 2'd2; phase_nxt = PH_BOOST1; end
         PH_BOOST1: begin src_lv = 2'd1; dst_lv = 2'd0; phase_nxt = PH_BOOST2; end
         PH_BOOST2: begin src_lv = 2'd2; dst_lv = 2'd0; phase_nxt = PH_DEM1;   end
         PH_DEM1:   begin src_lv = 2'd1; dst_lv = 2'd2; phase_nxt = PH_DEM0;   end
         PH_DEM0:   begin src_lv = 2'd0; dst_lv = 2'd1; phase_nxt = PH_ROT0;   end
         PH_ROT0:   begin src_lv = 2'd0; dst_lv = 2'd0; phase_nxt = PH_ROT1;   end
         PH_ROT1:   begin src_lv = 2'd1; dst_lv = 2'd1; phase_nxt = PH_ROT2;   end
         PH_ROT2:   begin src_lv = 2'd2; dst_lv = 2'd2; phase_nxt = PH_ROT2;   end
         default:   begin src_lv = 2'd0; dst_lv = 2'd0; phase_nxt = PH_PURGE0; end
      endcase
   end

   // Engine sequencing and queue updates.
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      n_in        = n_ff;
      cur_in      = cur_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      present_in  = present_ff;
      alive_in    = alive_ff;
      active_in   = active_ff;
      pick_cnt_in = pick_cnt_ff;
      res_in      = res_ff;
      q_take      = 1'b0;
      lw_en       = 1'b0;
      lw_addr     = '0;
      lw_data     = '0;
      uw_en       = 1'b0;
      uw_addr     = cur_ff;
      uw_data     = '0;
      cw_en       = 1'b0;
      cw_addr     = cmd_ff.id;
      cw_data     = cmd_ff.charge;
      pop_en      = 1'b0;
      push_en     = 1'b0;
      push_lv     = dst_lv;
      push_id     = cur_ff;
      pass_end    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_take   = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_in = '0;
            unique case (cmd_ff.op)
               OP_ADD: begin
                  if (present_ff[cmd_ff.id] || (total >= CNT_W'(CAP))) begin
                     res_in.status = ST_FULL;
                  end else begin
                     present_in[cmd_ff.id] = 1'b1;
                     alive_in[cmd_ff.id]   = 1'b1;
                     active_in[cmd_ff.id]  = cmd_ff.act;
                     cw_en   = 1'b1;
                     uw_en   = 1'b1;
                     uw_addr = cmd_ff.id;
                     push_en = 1'b1;
                     push_lv = 2'd0;
                     push_id = cmd_ff.id;
                  end
                  state_in = S_DONE;
               end
               OP_KILL: begin
                  if (!present_ff[cmd_ff.id]) begin
                     res_in.status = ST_UNKNOWN;
                  end else begin
                     alive_in[cmd_ff.id] = 1'b0;
                  end
                  state_in = S_DONE;
               end
               OP_SET: begin
                  if (!present_ff[cmd_ff.id]) begin
                     res_in.status = ST_UNKNOWN;
                  end else begin
                     active_in[cmd_ff.id] = cmd_ff.act;
                  end
                  state_in = S_DONE;
               end
               OP_PICK: begin
                  phase_in = PH_PURGE0;
                  state_in = S_INIT;
               end
               default: state_in = S_DONE;
            endcase
         end

         S_INIT: begin
            if ((phase_ff == PH_BOOST1) && (pick_cnt_ff < cfg.boost_period)) begin
               // No boost this pick: count it and go on to demotion.
               pick_cnt_in = pick_cnt_ff + PERIOD_W'(1);
               phase_in    = PH_DEM1;
            end else begin
               if (phase_ff == PH_BOOST1) begin
                  pick_cnt_in = PERIOD_W'(1);
               end
               n_in = count_ff[src_lv];
               if (count_ff[src_lv] == '0) begin
                  pass_end = 1'b1;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         S_RD: begin
            cur_in   = head_ff[src_lv];
            state_in = S_EX;
         end

         S_EX: begin
            n_in = n_dec;
            if ((phase_ff == PH_PURGE0) || (phase_ff == PH_PURGE1) ||
                (phase_ff == PH_PURGE2)) begin
               pop_en = 1'b1;
               if (alive_ff[cur_ff]) begin
                  push_en = 1'b1;
               end else begin
                  present_in[cur_ff] = 1'b0;
                  alive_in[cur_ff]   = 1'b0;
                  active_in[cur_ff]  = 1'b0;
               end
               pass_end = (n_dec == '0);
            end else if ((phase_ff == PH_BOOST1) || (phase_ff == PH_BOOST2)) begin
               pop_en   = 1'b1;
               push_en  = 1'b1;
               uw_en    = 1'b1;
               pass_end = (n_dec == '0);
            end else if ((phase_ff == PH_DEM1) || (phase_ff == PH_DEM0)) begin
               if (used_rd >= {1'b0, cfg.time_slice}) begin
                  pop_en   = 1'b1;
                  push_en  = 1'b1;
                  uw_en    = 1'b1;
                  pass_end = (n_dec == '0);
               end else begin
                  pass_end = 1'b1;
               end
            end else begin
               // Rotation: move the head to the tail and test it.
               pop_en  = 1'b1;
               push_en = 1'b1;
               if (active_ff[cur_ff] || cmd_ff.room) begin
                  uw_en   = 1'b1;
                  uw_data = used_sum[USED_W] ? USED_MAX : used_sum[USED_W-1:0];
                  res_in.picked_valid = 1'b1;
                  res_in.picked_id    = cur_ff;
                  res_in.picked_level = src_lv;
                  state_in = S_DONE;
               end else begin
                  pass_end = (n_dec == '0);
               end
            end
            if (!pass_end && (state_in != S_DONE)) begin
               state_in = S_RD;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      // A finished pass moves to the next one, or ends the pick.
      if (pass_end) begin
         if (phase_ff == PH_ROT2) begin
            state_in = S_DONE;
         end else begin
            phase_in = phase_nxt;
            state_in = S_INIT;
         end
      end

      // Unlink the head of the source level.
      if (pop_en) begin
         head_in[src_lv]  = link_rd;
         count_in[src_lv] = count_ff[src_lv] - CNT_W'(1);
      end

      // Append an element to the tail of a level.
      if (push_en) begin
         if (count_in[push_lv] == '0) begin
            head_in[push_lv] = push_id;
         end else begin
            lw_en   = 1'b1;
            lw_addr = tail_in[push_lv];
            lw_data = push_id;
         end
         tail_in[push_lv]  = push_id;
         count_in[push_lv] = count_in[push_lv] + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= PH_PURGE0;
         head_ff     <= '{default: '0};
         tail_ff     <= '{default: '0};
         count_ff    <= '{default: '0};
         present_ff  <= '0;
         alive_ff    <= '0;
         active_ff   <= '0;
         pick_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         present_ff  <= present_in;
         alive_ff    <= alive_in;
         active_ff   <= active_in;
         pick_cnt_ff <= pick_cnt_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      n_ff   <= n_in;
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   // Task memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (lw_en) begin
         link_mem[lw_addr] <= lw_data;
      end
      if (uw_en) begin
         used_mem[uw_addr] <= uw_data;
      end
      if (cw_en) begin
         chg_mem[cw_addr] <= cw_data;
      end
      link_rd <= link_mem[rd_addr];
      used_rd <= used_mem[rd_addr];
      chg_rd  <= chg_mem[rd_addr];
   end

   // Result beat.
   assign rsp_valid = (state_ff == S_DONE);
   always_comb begin
      rsp_item            = res_ff;
      rsp_item.task_total = total;
   end

endmodule

// ----- sv/three_level_feedback_queue_scheduler_core.sv -----
// ============================================================================
// three_level_feedback_queue_scheduler_core
// Three-level feedback queue scheduler with a command front end, a two-entry
// command queue and a list-walking scheduling engine.
//
//   channel   ports                          beat taken when
//   --------  -----------------------------  -------------------------------
//   request   start, busy, req_item          start high and busy low
//   response  rsp_valid, rsp_item            rsp_valid high (one cycle)
//   config    psel, penable, pwrite, paddr,  psel, penable, pwrite, pready
//             pwdata, prdata, pready
//
// Add, kill and set-active pass through the engine's execute and done
// states. A pick starts six to ten passes, each with a set-up state, and
// reads the queue elements of its purge, boost, demotion and rotation
// passes, up to five times MAX_TASKS; each element costs a memory read and
// an update. Reset is synchronous and leaves all queues empty.
// Up to two commands wait in the queue; busy rises when it is full. The
// receiver cannot stall the response.
// ============================================================================
module three_level_feedback_queue_scheduler_core
   import tfq_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int CAP = (MAX_TASKS < ID_SPACE) ? MAX_TASKS : ID_SPACE;

   logic [SLICE_W-1:0]  time_slice_ff, time_slice_in;
   logic [PERIOD_W-1:0] boost_period_ff, boost_period_in;
   logic                wr_beat;
   cfg_type             cfg;
   logic                q_valid;
   cmd_type             q_cmd;
   logic                q_take;

   // Configuration registers.
   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite && pready;

   always_comb begin
      time_slice_in   = time_slice_ff;
      boost_period_in = boost_period_ff;
      if (wr_beat) begin
         case (paddr[2])
            REG_TIME_SLICE:   time_slice_in   = pwdata[SLICE_W-1:0];
            REG_BOOST_PERIOD: boost_period_in = pwdata[PERIOD_W-1:0];
            default:          time_slice_in   = time_slice_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_slice_ff   <= SLICE_RESET;
         boost_period_ff <= PERIOD_RESET;
      end else begin
         time_slice_ff   <= time_slice_in;
         boost_period_ff <= boost_period_in;
      end
   end

   assign prdata = (paddr[2] == REG_BOOST_PERIOD) ? {22'd0, boost_period_ff}
                                                  : {24'd0, time_slice_ff};

   assign cfg.time_slice   = time_slice_ff;
   assign cfg.boost_period = boost_period_ff;

   // Front end and command queue.
   tfq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_take   (q_take)
   );

   // Scheduling engine.
   tfq_back #(
      .MAX_TASKS (MAX_TASKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Two result beats never come back to back.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   // A chosen task always comes with an ok status.
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.picked_valid) |-> (rsp_item.status == ST_OK))
      else $error("picked task with error status");

   // The store never holds more tasks than its capacity.
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.task_total <= CNT_W'(CAP)))
      else $error("task total above capacity");

endmodule

// ----- test/testbench.sv -----
// ============================================================================
// Scheduler core testbench
// Drives add, kill, set-active and pick commands into the three-level feedback
// queue scheduler. A queue-based scheduler model inside the bench predicts the
// response beats, directed rows may carry expected values of their own, and each
// beat is checked field by field. Directed rows come first, then a store-fill
// sweep, then random traffic under several time-slice and boost-period settings.
// ============================================================================
module testbench;
   import tfq_pkg::*;

   localparam int STALL_LIMIT = 50000;
   localparam int RAND_PER_PHASE = 335;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   three_level_feedback_queue_scheduler_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Scheduler model state.
   logic              sch_present [ID_SPACE];
   logic              sch_alive [ID_SPACE];
   logic              sch_active [ID_SPACE];
   logic [CHG_W-1:0]  sch_charge [ID_SPACE];
   logic [USED_W-1:0] sch_used [ID_SPACE];
   logic [ID_W-1:0]   sch_level_q [NUM_LEVELS][$];
   logic [PERIOD_W-1:0] sch_pick_count = '0;
   logic [SLICE_W-1:0]  cfg_slice = SLICE_RESET;
   logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;

   rsp_item_type expected_rsp[$];
   int  errors = 0;
   int  items_sent = 0;
   int  picks_chosen = 0;
   int  full_rejects = 0;
   int  stall_cycles = 0;
   bit  idle_on = 1'b1;
   logic accepted_now = 1'b0;

   typedef struct {
      req_item_type it;
      bit           typed;
      rsp_item_type ex;
   } stim_row_type;

   stim_row_type stim_table[$];

   function automatic int unsigned held_total();
      return sch_level_q[0].size() + sch_level_q[1].size() + sch_level_q[2].size();
   endfunction

   // Move heads of one level whose used time reached the slice down a level.
   function automatic void demote_heads(int from_lv, int to_lv);
      int n;
      logic [ID_W-1:0] t;
      n = sch_level_q[from_lv].size();
      for (int i = 0; i < n; i++) begin
         if (sch_level_q[from_lv].size() == 0) break;
         t = sch_level_q[from_lv][0];
         if (sch_used[t] < USED_W'(cfg_slice)) break;
         void'(sch_level_q[from_lv].pop_front());
         sch_used[t] = '0;
         sch_level_q[to_lv].push_back(t);
      end
   endfunction

   // Apply one command to the model and return the response it produces.
   function automatic rsp_item_type schedule_step(req_item_type it);
      rsp_item_type r;
      logic [ID_W-1:0] id, t;
      int n;
      int unsigned sum;
      r = '0;
      id = it.task_id;
      case (op_type'(it.opcode))
         OP_ADD: begin
            if (sch_present[id] || held_total() >= DEF_MAX_TASKS) begin
               r.status = ST_FULL;
            end else begin
               sch_present[id] = 1'b1;
               sch_alive[id] = 1'b1;
               sch_active[id] = it.active_flag;
               sch_charge[id] = it.charge;
               sch_used[id] = '0;
               sch_level_q[0].push_back(id);
            end
         end
         OP_KILL: begin
            if (!sch_present[id]) r.status = ST_UNKNOWN;
            else sch_alive[id] = 1'b0;
         end
         OP_SET: begin
            if (!sch_present[id]) r.status = ST_UNKNOWN;
            else sch_active[id] = it.active_flag;
         end
         default: begin
            // Purge dead tasks, keeping the order of the living ones.
            for (int lv = 0; lv < NUM_LEVELS; lv++) begin
               n = sch_level_q[lv].size();
               for (int i = 0; i < n; i++) begin
                  t = sch_level_q[lv].pop_front();
                  if (sch_alive[t]) begin
                     sch_level_q[lv].push_back(t);
                  end else begin
                     sch_present[t] = 1'b0;
                     sch_alive[t] = 1'b0;
                     sch_active[t] = 1'b0;
                  end
               end
            end
            // Periodic boost of mid and low tasks to the high level.
            if (sch_pick_count >= cfg_period) begin
               sch_pick_count = '0;
               for (int lv = 1; lv < NUM_LEVELS; lv++) begin
                  while (sch_level_q[lv].size() != 0) begin
                     t = sch_level_q[lv].pop_front();
                     sch_used[t] = '0;
                     sch_level_q[0].push_back(t);
                  end
               end
            end
            sch_pick_count = sch_pick_count + 1'b1;
            demote_heads(1, 2);
            demote_heads(0, 1);
            // Rotate through the levels until an eligible task comes up.
            for (int lv = 0; lv < NUM_LEVELS && !r.picked_valid; lv++) begin
               n = sch_level_q[lv].size();
               for (int i = 0; i < n; i++) begin
                  t = sch_level_q[lv].pop_front();
                  sch_level_q[lv].push_back(t);
                  if (sch_active[t] || it.spawn_room) begin
                     sum = sch_used[t] + sch_charge[t];
                     sch_used[t] = (sum > USED_MAX) ? USED_MAX : USED_W'(sum);
                     r.picked_valid = 1'b1;
                     r.picked_id = t;
                     r.picked_level = LVL_W'(lv);
                     break;
                  end
               end
            end
         end
      endcase
      r.task_total = CNT_W'(held_total());
      return r;
   endfunction

   // Send one command beat; hold start until the core takes it.
   task automatic send_cmd(req_item_type it, bit typed, rsp_item_type ex);
      logic was_busy;
      rsp_item_type pred;
      if (idle_on && $urandom_range(99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      accepted_now <= ~accepted_now;
      pred = schedule_step(it);
      if (pred.status == ST_FULL) full_rejects++;
      if (pred.picked_valid) picks_chosen++;
      expected_rsp.push_back(typed ? ex : pred);
      items_sent++;
   endtask

   // Let every expected response arrive before touching the registers.
   task automatic drain();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(logic idx, bit wr, logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Write both registers, read them back, and mirror them in the model.
   task automatic set_config(logic [SLICE_W-1:0] slice, logic [PERIOD_W-1:0] period);
      logic [31:0] rd;
      csr_access(REG_TIME_SLICE, 1'b1, 32'(slice), rd);
      csr_access(REG_BOOST_PERIOD, 1'b1, 32'(period), rd);
      cfg_slice = slice;
      cfg_period = period;
      csr_access(REG_TIME_SLICE, 1'b0, '0, rd);
      if (rd[SLICE_W-1:0] !== slice) begin
         $display("%0t: time_slice readback expected %0d actual %0d", $realtime, slice,
                  rd[SLICE_W-1:0]);
         errors++;
      end
      csr_access(REG_BOOST_PERIOD, 1'b0, '0, rd);
      if (rd[PERIOD_W-1:0] !== period) begin
         $display("%0t: boost_period readback expected %0d actual %0d", $realtime, period,
                  rd[PERIOD_W-1:0]);
         errors++;
      end
   endtask

   function automatic req_item_type mk_cmd(op_type op, int id, int chg, bit act, bit room);
      req_item_type it;
      it.opcode = op;
      it.task_id = ID_W'(id);
      it.charge = CHG_W'(chg);
      it.active_flag = act;
      it.spawn_room = room;
      return it;
   endfunction

   function automatic void add_row(req_item_type it, bit typed, bit v = 0, int pid = 0,
                                   int plev = 0, int total = 0, status_type st = ST_OK);
      stim_row_type row;
      row.it = it;
      row.typed = typed;
      row.ex.picked_valid = v;
      row.ex.picked_id = ID_W'(pid);
      row.ex.picked_level = LVL_W'(plev);
      row.ex.task_total = CNT_W'(total);
      row.ex.status = st;
      stim_table.push_back(row);
   endfunction

   // Random command: mostly a small id pool so tasks collide, sometimes any id.
   function automatic req_item_type rand_cmd();
      req_item_type it;
      int sel;
      int chg;
      sel = $urandom_range(99);
      chg = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255);
      if ($urandom_range(9) < 3) chg = $urandom_range(15);
      it = mk_cmd(sel < 30 ? OP_ADD : sel < 43 ? OP_KILL : sel < 58 ? OP_SET : OP_PICK,
                  ($urandom_range(99) < 80) ? $urandom_range(15) : $urandom_range(63),
                  chg, $urandom_range(1), $urandom_range(1));
      return it;
   endfunction

   // Response checker: every beat is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type ex;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response beat %p", $realtime, rsp_item);
            errors++;
         end else begin
            ex = expected_rsp.pop_front();
            if (rsp_item.picked_valid !== ex.picked_valid || rsp_item.picked_id !== ex.picked_id
                || rsp_item.picked_level !== ex.picked_level
                || rsp_item.task_total !== ex.task_total || rsp_item.status !== ex.status) begin
               $display("%0t: response mismatch expected %p actual %p", $realtime, ex,
                        rsp_item);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles in which no beat moves in either direction.
   logic accepted_seen = 1'b0;
   always @(posedge clock) begin
      if (reset || rsp_valid || accepted_now != accepted_seen) begin
         stall_cycles <= 0;
         accepted_seen <= accepted_now;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      rsp_item_type no_ex;
      no_ex = '0;
      for (int i = 0; i < ID_SPACE; i++) begin
         sch_present[i] = 1'b0;
         sch_alive[i] = 1'b0;
         sch_active[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: empty pick, unknown ids, duplicates, extremes, kill and purge.
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 1), 1, 0, 0, 0, 0, ST_OK);
      add_row(mk_cmd(OP_KILL, 5, 0, 0, 0), 1, 0, 0, 0, 0, ST_UNKNOWN);
      add_row(mk_cmd(OP_SET, 63, 255, 1, 1), 1, 0, 0, 0, 0, ST_UNKNOWN);
      add_row(mk_cmd(OP_ADD, 0, 255, 1, 0), 1, 0, 0, 0, 1, ST_OK);
      add_row(mk_cmd(OP_ADD, 0, 17, 0, 1), 1, 0, 0, 0, 1, ST_FULL);
      add_row(mk_cmd(OP_ADD, 63, 0, 0, 0), 1, 0, 0, 0, 2, ST_OK);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 0), 1, 1, 0, 0, 2, ST_OK);
      add_row(mk_cmd(OP_PICK, 63, 255, 1, 1), 0);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 0), 0);
      add_row(mk_cmd(OP_SET, 63, 0, 1, 0), 0);
      add_row(mk_cmd(OP_ADD, 42, 85, 1, 0), 0);
      add_row(mk_cmd(OP_ADD, 21, 170, 0, 1), 0);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 0), 0);
      add_row(mk_cmd(OP_KILL, 0, 0, 0, 0), 0);
      add_row(mk_cmd(OP_KILL, 0, 0, 0, 0), 0);
      add_row(mk_cmd(OP_SET, 0, 0, 0, 0), 0);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 0), 0);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 1), 0);
      add_row(mk_cmd(OP_SET, 42, 0, 0, 0), 0);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 0), 0);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 1), 0);
      add_row(mk_cmd(OP_KILL, 42, 0, 0, 0), 0);
      add_row(mk_cmd(OP_PICK, 0, 0, 0, 1), 0);
      foreach (stim_table[i]) send_cmd(stim_table[i].it, stim_table[i].typed, stim_table[i].ex);

      // Fill the store, hit the full case, then kill everything and purge it.
      for (int i = 0; i < ID_SPACE; i++)
         send_cmd(mk_cmd(OP_ADD, i, $urandom_range(255), $urandom_range(1), 0), 0, no_ex);
      send_cmd(mk_cmd(OP_ADD, 7, 3, 1, 0), 0, no_ex);
      repeat (30) send_cmd(mk_cmd(OP_PICK, 0, 0, 0, $urandom_range(1)), 0, no_ex);
      for (int i = 0; i < ID_SPACE; i++) send_cmd(mk_cmd(OP_KILL, i, 0, 0, 0), 0, no_ex);
      send_cmd(mk_cmd(OP_PICK, 0, 0, 0, 1), 0, no_ex);

      // Random phases under different register settings, extremes included.
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         case (ph)
            0: set_config(1, 1);
            1: set_config(255, 1023);
            2: set_config(0, 0);
            default: set_config($urandom_range(1, 40), $urandom_range(1, 60));
         endcase
         idle_on = (ph != 1);
         repeat (RAND_PER_PHASE) send_cmd(rand_cmd(), 0, no_ex);
      end
      drain();

      $display("Sent %0d commands over six register settings; %0d picks chose a task.",
               items_sent, picks_chosen);
      $display("Adds rejected as full or duplicate: %0d.", full_rejects);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
